FILE: hw/rtl/hkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Held key tracker package
// Shared widths, register indexes, reset codes and control structs.
// ----------------------------------------------------------------------------
package hkt_pkg;

   localparam int CODE_W       = 16;
   localparam int KEY_W        = 32;
   localparam int CSR_IDX_W    = 3;
   localparam int NUM_REGS     = 7;
   localparam int NUM_SLOTS    = 6;
   localparam int RELEASE_BIT  = 7;

   localparam logic [CODE_W-1:0] RELEASE_OFFSET = 16'h0080;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_SHIFT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_SHIFT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_CTRL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_CTRL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_ALT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_ALT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CAPS_LOCK   = 3'd6;

   typedef logic [CODE_W-1:0] code_type;

   // Reset press codes, scan set 1, in register index order.
   localparam code_type REG_RESET [NUM_REGS] = '{
      16'h002A, 16'h0036, 16'h001D, 16'hE01D, 16'h0038, 16'hE038, 16'h003A
   };

   // What the key map says about the current code.
   typedef struct packed {
      logic is_shift;
      logic is_ctrl;
      logic is_alt;
      logic is_caps;
   } key_class_type;

   // Broadcast to every cell of the held list.
   typedef struct packed {
      logic     insert;
      logic     release_en;
      code_type code;
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/hkt_keymap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Held key tracker key map
// Modifier code registers and classification of the incoming code.
// ----------------------------------------------------------------------------
module hkt_keymap (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [hkt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hkt_pkg::CODE_W-1:0]     csr_data,
   input  hkt_pkg::code_type              code,
   output hkt_pkg::key_class_type         key_class
);

   hkt_pkg::code_type regs_ff [hkt_pkg::NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hkt_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= hkt_pkg::REG_RESET[i];
         end
      end else if (csr_valid && (32'(csr_index) < hkt_pkg::NUM_REGS)) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   always_comb begin
      key_class.is_shift = (code == regs_ff[hkt_pkg::REG_LEFT_SHIFT]) ||
                           (code == regs_ff[hkt_pkg::REG_RIGHT_SHIFT]);
      key_class.is_ctrl  = (code == regs_ff[hkt_pkg::REG_LEFT_CTRL]) ||
                           (code == regs_ff[hkt_pkg::REG_RIGHT_CTRL]);
      key_class.is_alt   = (code == regs_ff[hkt_pkg::REG_LEFT_ALT]) ||
                           (code == regs_ff[hkt_pkg::REG_RIGHT_ALT]);
      key_class.is_caps  = (code == regs_ff[hkt_pkg::REG_CAPS_LOCK]);
   end

endmodule

FILE: hw/rtl/hkt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Held key tracker cell
// One slot of the held list: compares, shifts in from its newer neighbor,
// and clears itself on the first matching release.
// ----------------------------------------------------------------------------
module hkt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  hkt_pkg::cell_ctrl_type ctrl,
   input  hkt_pkg::code_type      entry_prev,
   input  logic                   found_prev,
   output hkt_pkg::code_type      entry,
   output logic                   found
);

   hkt_pkg::code_type entry_ff;
   hkt_pkg::code_type entry_in;
   logic              hit;

   assign hit   = (entry_ff == ctrl.code);
   assign found = found_prev || hit;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         entry_in = entry_prev;
      end else if (ctrl.release_en && hit && !found_prev) begin
         entry_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

FILE: hw/rtl/keyboard_held_key_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard held key tracker
// Tracks held keys, modifier flags and caps lock from decoded key codes.
// ----------------------------------------------------------------------------
// The block takes one decoded scan-set-1 key code per beat and returns one
// result beat per code, in the cycle after it is accepted. A new code is taken
// every cycle as long as the result side keeps up; the rate is set by the
// single output register, which holds a result until it is taken and stalls
// the request side meanwhile. The held list is a chain of LIST_DEPTH cells,
// slot 0 the newest: a new press shifts every cell into its older neighbor
// and enters slot 0, while a release clears the first cell that holds its
// code, found through a ripple of match bits down the chain. Shift, ctrl and
// alt flags follow their press and release codes, caps lock toggles on each
// press, and codes above 0xFFFF change nothing and are flagged as ignored.
// The slot and flag outputs show the state after the most recent item. The
// modifier codes are programmable through the csr port, which is always
// ready; writes belong in idle periods only.
// ----------------------------------------------------------------------------
module keyboard_held_key_tracker #(
   parameter int LIST_DEPTH = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hkt_pkg::KEY_W-1:0]     req_key_code,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hkt_pkg::CODE_W-1:0]    rsp_slot_zero,
   output logic [hkt_pkg::CODE_W-1:0]    rsp_slot_one,
   output logic [hkt_pkg::CODE_W-1:0]    rsp_slot_two,
   output logic [hkt_pkg::CODE_W-1:0]    rsp_slot_three,
   output logic [hkt_pkg::CODE_W-1:0]    rsp_slot_four,
   output logic [hkt_pkg::CODE_W-1:0]    rsp_slot_five,
   output logic                          rsp_shift_held,
   output logic                          rsp_ctrl_held,
   output logic                          rsp_alt_held,
   output logic                          rsp_caps_lock_on,
   output logic                          rsp_modifier_pressed,
   output logic                          rsp_code_ignored,
   // Configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hkt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hkt_pkg::CODE_W-1:0]    csr_data
);

   logic                   accept;
   logic                   in_range;
   logic                   is_release;
   hkt_pkg::code_type      code;
   hkt_pkg::key_class_type key_class;
   hkt_pkg::cell_ctrl_type cell_ctrl;
   logic                   press_other;
   logic                   listed;

   hkt_pkg::code_type entry_chain [LIST_DEPTH+1];
   logic              found_chain [LIST_DEPTH+1];
   hkt_pkg::code_type slot_out    [hkt_pkg::NUM_SLOTS];

   logic rsp_valid_ff, rsp_valid_in;
   logic shift_ff, shift_in;
   logic ctrl_ff, ctrl_in;
   logic alt_ff, alt_in;
   logic caps_ff, caps_in;
   logic mod_pulse_ff, mod_pulse_in;
   logic ignored_ff, ignored_in;

   // A new code is only taken when the result register is free or drains now,
   // so the state registers always match the result on display.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_range   = (req_key_code[hkt_pkg::KEY_W-1:hkt_pkg::CODE_W] == '0);
   assign is_release = req_key_code[hkt_pkg::RELEASE_BIT];

   // Release codes are matched against their press form.
   always_comb begin
      code = req_key_code[hkt_pkg::CODE_W-1:0];
      if (is_release) begin
         code = req_key_code[hkt_pkg::CODE_W-1:0] - hkt_pkg::RELEASE_OFFSET;
      end
   end

   hkt_keymap u_keymap (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .code      (code),
      .key_class (key_class)
   );

   // Caps lock only counts as special on a press; its release is searched in
   // the list like an ordinary key.
   assign press_other = accept && in_range && !is_release &&
                        !key_class.is_shift && !key_class.is_ctrl &&
                        !key_class.is_alt && !key_class.is_caps;

   assign listed = found_chain[LIST_DEPTH];

   always_comb begin
      cell_ctrl.code       = code;
      cell_ctrl.insert     = press_other && !listed;
      cell_ctrl.release_en = accept && in_range && is_release &&
                             !key_class.is_shift && !key_class.is_ctrl &&
                             !key_class.is_alt;
   end

   assign entry_chain[0] = code;
   assign found_chain[0] = 1'b0;

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      hkt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .entry_prev (entry_chain[i]),
         .found_prev (found_chain[i]),
         .entry      (entry_chain[i+1]),
         .found      (found_chain[i+1])
      );
   end

   // Slots past the end of a short list read as empty.
   for (genvar i = 0; i < hkt_pkg::NUM_SLOTS; i++) begin : g_slot
      if (i < LIST_DEPTH) begin : g_used
         assign slot_out[i] = entry_chain[i+1];
      end else begin : g_empty
         assign slot_out[i] = '0;
      end
   end

   // Modifier flags follow shift first, then ctrl, then alt, then caps lock.
   always_comb begin
      shift_in     = shift_ff;
      ctrl_in      = ctrl_ff;
      alt_in       = alt_ff;
      caps_in      = caps_ff;
      mod_pulse_in = mod_pulse_ff;
      ignored_in   = ignored_ff;
      if (accept) begin
         mod_pulse_in = 1'b0;
         ignored_in   = !in_range;
         if (in_range) begin
            priority if (key_class.is_shift) begin
               shift_in     = !is_release;
               mod_pulse_in = !is_release;
            end else if (key_class.is_ctrl) begin
               ctrl_in      = !is_release;
               mod_pulse_in = !is_release;
            end else if (key_class.is_alt) begin
               alt_in       = !is_release;
               mod_pulse_in = !is_release;
            end else if (key_class.is_caps && !is_release) begin
               caps_in = !caps_ff;
            end else begin
               caps_in = caps_ff;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         alt_ff       <= 1'b0;
         caps_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         shift_ff     <= shift_in;
         ctrl_ff      <= ctrl_in;
         alt_ff       <= alt_in;
         caps_ff      <= caps_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_pulse_ff <= mod_pulse_in;
      ignored_ff   <= ignored_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_slot_zero        = slot_out[0];
   assign rsp_slot_one         = slot_out[1];
   assign rsp_slot_two         = slot_out[2];
   assign rsp_slot_three       = slot_out[3];
   assign rsp_slot_four        = slot_out[4];
   assign rsp_slot_five        = slot_out[5];
   assign rsp_shift_held       = shift_ff;
   assign rsp_ctrl_held        = ctrl_ff;
   assign rsp_alt_held         = alt_ff;
   assign rsp_caps_lock_on     = caps_ff;
   assign rsp_modifier_pressed = mod_pulse_ff;
   assign rsp_code_ignored     = ignored_ff;

endmodule

FILE: hw/rtl/hkt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Held key tracker checker
// Port-level assertions on the tracker, attached through bind.
// ----------------------------------------------------------------------------
module hkt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [hkt_pkg::KEY_W-1:0]     req_key_code,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [hkt_pkg::CODE_W-1:0]    rsp_slot_zero,
   input logic                          rsp_shift_held,
   input logic                          rsp_ctrl_held,
   input logic                          rsp_alt_held,
   input logic                          rsp_modifier_pressed,
   input logic                          rsp_code_ignored
);

   logic req_fire;
   logic oversized;

   assign req_fire  = req_valid && !req_stall;
   assign oversized = (req_key_code[hkt_pkg::KEY_W-1:hkt_pkg::CODE_W] != '0);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_zero) &&
         $stable(rsp_code_ignored))
      else $error("stalled result beat changed");

   // Every accepted code shows its result in the next cycle.
   a_ignored: assert property (@(posedge clock) disable iff (reset)
      req_fire && oversized |=> rsp_valid && rsp_code_ignored)
      else $error("oversized code not flagged as ignored");

   a_not_ignored: assert property (@(posedge clock) disable iff (reset)
      req_fire && !oversized |=> rsp_valid && !rsp_code_ignored)
      else $error("in-range code flagged as ignored");

   // A modifier press always leaves its flag held.
   a_mod_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_modifier_pressed |->
         !rsp_code_ignored && (rsp_shift_held || rsp_ctrl_held || rsp_alt_held))
      else $error("modifier pulse without a held modifier");

endmodule

bind keyboard_held_key_tracker hkt_checker u_hkt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .req_key_code         (req_key_code),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_slot_zero        (rsp_slot_zero),
   .rsp_shift_held       (rsp_shift_held),
   .rsp_ctrl_held        (rsp_ctrl_held),
   .rsp_alt_held         (rsp_alt_held),
   .rsp_modifier_pressed (rsp_modifier_pressed),
   .rsp_code_ignored     (rsp_code_ignored)
);

FILE: tb/keyboard_held_key_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard held key tracker testbench
// Self-checking bench: a short directed table of key codes, then random
// press and release traffic under several key maps. The list, flag and
// caps lock outputs are compared field by field against the table or a behavioral tracker.
// ----------------------------------------------------------------------------
module keyboard_held_key_tracker_tb;

   // The bench runs the block at its default list depth of six slots.
   localparam int DEPTH            = 6;
   localparam int DIRECTED_ROWS    = 27;
   localparam int RANDOM_PER_PHASE = 196;
   localparam int POOL_SIZE        = 16;
   // The result is registered straight from the accepted request, so a handful of
   // quiet cycles is plenty once every expected beat has come back.
   localparam int DRAIN_CYCLES     = 4;
   localparam int CYCLE_LIMIT      = 500000;

   localparam logic [hkt_pkg::CSR_IDX_W-1:0] REG_UNUSED  = 3'd7;
   localparam hkt_pkg::code_type             RELEASE_OFS = 16'h0080;

   typedef hkt_pkg::code_type key_map_type [hkt_pkg::NUM_REGS];

   // Press codes that the key map holds right after reset.
   localparam key_map_type DEFAULT_MAP = '{
      16'h002A, 16'h0036, 16'h001D, 16'hE01D, 16'h0038, 16'hE038, 16'h003A
   };

   // One result beat as the block presents it.
   typedef struct packed {
      hkt_pkg::code_type slot_zero;
      hkt_pkg::code_type slot_one;
      hkt_pkg::code_type slot_two;
      hkt_pkg::code_type slot_three;
      hkt_pkg::code_type slot_four;
      hkt_pkg::code_type slot_five;
      logic              shift_held;
      logic              ctrl_held;
      logic              alt_held;
      logic              caps_lock_on;
      logic              modifier_pressed;
      logic              code_ignored;
   } tracker_view_type;

   // A row of the directed table. Where typed is set, the row is taken while
   // the held list is still empty, so the whole expected beat is the six
   // flag bits {shift, ctrl, alt, caps, modifier pulse, ignored}.
   typedef struct packed {
      logic [hkt_pkg::KEY_W-1:0] key;
      logic                      typed;
      logic [5:0]                flags;
   } key_row_type;

   // Key map settings that the run steps through, one per phase.
   typedef enum int {
      MAP_DEFAULT,
      MAP_ZERO,
      MAP_ONES,
      MAP_SHARED,
      MAP_PRESS_CODES,
      MAP_ANY,
      MAP_RESTORE
   } map_kind_type;

   // Result side back-pressure, chosen anew for each window of cycles.
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // -------------------------------------------------------------------------
   // Block ports. Every input holds a known value from time zero.
   // -------------------------------------------------------------------------
   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic [hkt_pkg::KEY_W-1:0]     req_key_code = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   hkt_pkg::code_type             rsp_slot_zero;
   hkt_pkg::code_type             rsp_slot_one;
   hkt_pkg::code_type             rsp_slot_two;
   hkt_pkg::code_type             rsp_slot_three;
   hkt_pkg::code_type             rsp_slot_four;
   hkt_pkg::code_type             rsp_slot_five;
   logic                          rsp_shift_held;
   logic                          rsp_ctrl_held;
   logic                          rsp_alt_held;
   logic                          rsp_caps_lock_on;
   logic                          rsp_modifier_pressed;
   logic                          rsp_code_ignored;
   logic                          csr_valid    = 1'b0;
   logic                          csr_ready;
   logic [hkt_pkg::CSR_IDX_W-1:0] csr_index    = '0;
   hkt_pkg::code_type             csr_data     = '0;

   keyboard_held_key_tracker #(
      .LIST_DEPTH(DEPTH)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_key_code        (req_key_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_slot_zero       (rsp_slot_zero),
      .rsp_slot_one        (rsp_slot_one),
      .rsp_slot_two        (rsp_slot_two),
      .rsp_slot_three      (rsp_slot_three),
      .rsp_slot_four       (rsp_slot_four),
      .rsp_slot_five       (rsp_slot_five),
      .rsp_shift_held      (rsp_shift_held),
      .rsp_ctrl_held       (rsp_ctrl_held),
      .rsp_alt_held        (rsp_alt_held),
      .rsp_caps_lock_on    (rsp_caps_lock_on),
      .rsp_modifier_pressed(rsp_modifier_pressed),
      .rsp_code_ignored    (rsp_code_ignored),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Behavioral tracker: its own key map, held list and flags, advanced once
   // per accepted request beat.
   // -------------------------------------------------------------------------
   key_map_type       key_map      = DEFAULT_MAP;
   hkt_pkg::code_type held_codes [DEPTH];
   logic              shift_on     = 1'b0;
   logic              ctrl_on      = 1'b0;
   logic              alt_on       = 1'b0;
   logic              caps_on      = 1'b0;

   tracker_view_type  expected_views [$];
   key_row_type       directed_rows [DIRECTED_ROWS];
   hkt_pkg::code_type key_pool [POOL_SIZE];

   int                beats_sent     = 0;
   int                beats_checked  = 0;
   int                reg_writes     = 0;
   int                error_count    = 0;
   int                burst_left     = 0;
   int                cycle_count    = 0;
   stall_mode_type    stall_mode     = STALL_NONE;
   int                stall_window   = 0;

   initial begin
      foreach (held_codes[i]) held_codes[i] = '0;
   end

   function automatic tracker_view_type track_key(input logic [hkt_pkg::KEY_W-1:0] raw);
      tracker_view_type  view;
      hkt_pkg::code_type code;
      logic              listed;
      logic              cleared;
      view    = '0;
      listed  = 1'b0;
      cleared = 1'b0;
      if (raw > 32'h0000_FFFF) begin
         // Oversized codes leave every piece of state alone.
         view.code_ignored = 1'b1;
      end else if (!raw[7]) begin
         code = raw[15:0];
         // Shift is matched first, then ctrl, alt and caps lock.
         if (code == key_map[hkt_pkg::REG_LEFT_SHIFT] ||
             code == key_map[hkt_pkg::REG_RIGHT_SHIFT]) begin
            shift_on              = 1'b1;
            view.modifier_pressed = 1'b1;
         end else if (code == key_map[hkt_pkg::REG_LEFT_CTRL] ||
                      code == key_map[hkt_pkg::REG_RIGHT_CTRL]) begin
            ctrl_on               = 1'b1;
            view.modifier_pressed = 1'b1;
         end else if (code == key_map[hkt_pkg::REG_LEFT_ALT] ||
                      code == key_map[hkt_pkg::REG_RIGHT_ALT]) begin
            alt_on                = 1'b1;
            view.modifier_pressed = 1'b1;
         end else if (code == key_map[hkt_pkg::REG_CAPS_LOCK]) begin
            caps_on = ~caps_on;
         end else begin
            // A code already held is dropped; code zero also matches any
            // empty slot, so it only gets in when the list is full.
            for (int i = 0; i < DEPTH; i++)
               if (held_codes[i] == code) listed = 1'b1;
            if (!listed) begin
               for (int i = DEPTH - 1; i > 0; i--)
                  held_codes[i] = held_codes[i-1];
               held_codes[0] = code;
            end
         end
      end else begin
         code = raw[15:0] - RELEASE_OFS;
         // Caps lock release is not special; it is looked up in the list.
         if (code == key_map[hkt_pkg::REG_LEFT_SHIFT] ||
             code == key_map[hkt_pkg::REG_RIGHT_SHIFT]) begin
            shift_on = 1'b0;
         end else if (code == key_map[hkt_pkg::REG_LEFT_CTRL] ||
                      code == key_map[hkt_pkg::REG_RIGHT_CTRL]) begin
            ctrl_on = 1'b0;
         end else if (code == key_map[hkt_pkg::REG_LEFT_ALT] ||
                      code == key_map[hkt_pkg::REG_RIGHT_ALT]) begin
            alt_on = 1'b0;
         end else begin
            for (int i = 0; i < DEPTH; i++) begin
               if (!cleared && held_codes[i] == code) begin
                  held_codes[i] = '0;
                  cleared       = 1'b1;
               end
            end
         end
      end
      view.slot_zero    = held_codes[0];
      view.slot_one     = held_codes[1];
      view.slot_two     = held_codes[2];
      view.slot_three   = held_codes[3];
      view.slot_four    = held_codes[4];
      view.slot_five    = held_codes[5];
      view.shift_held   = shift_on;
      view.ctrl_held    = ctrl_on;
      view.alt_held     = alt_on;
      view.caps_lock_on = caps_on;
      return view;
   endfunction

   // -------------------------------------------------------------------------
   // Random code sources.
   // -------------------------------------------------------------------------

   // A press code: mostly plain or E0-prefixed keys, now and then any prefix.
   function automatic hkt_pkg::code_type random_press_code();
      logic [7:0] prefix;
      case ($urandom_range(0, 3))
         0, 1:    prefix = 8'h00;
         2:       prefix = 8'hE0;
         default: prefix = 8'($urandom_range(0, 255));
      endcase
      return {prefix, 1'b0, 7'($urandom_range(0, 127))};
   endfunction

   function automatic key_map_type choose_map(input map_kind_type kind);
      key_map_type       map;
      hkt_pkg::code_type shared;
      case (kind)
         MAP_ZERO: map = '{default: 16'h0000};
         // All ones can never be pressed, so no code acts as a modifier or caps lock.
         MAP_ONES: map = '{default: 16'hFFFF};
         // Every register on one code exercises the match order.
         MAP_SHARED: begin
            shared = random_press_code();
            map    = '{default: shared};
         end
         MAP_PRESS_CODES: begin
            foreach (map[r]) map[r] = random_press_code();
         end
         MAP_ANY: begin
            foreach (map[r]) map[r] = hkt_pkg::code_type'($urandom_range(0, 65535));
         end
         default: map = DEFAULT_MAP;
      endcase
      return map;
   endfunction

   // The key pool holds the current modifier codes plus a few ordinary keys,
   // enough to fill the list and to make releases and repeats hit often.
   task automatic refill_pool();
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = (i < hkt_pkg::NUM_REGS) ? key_map[i] : random_press_code();
   endtask

   function automatic logic [hkt_pkg::KEY_W-1:0] random_key_code();
      logic [hkt_pkg::KEY_W-1:0] raw;
      hkt_pkg::code_type         pick;
      int                        sel;
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
         raw = $urandom;
         if (raw[31:16] == '0) raw[16] = 1'b1;
      end else if (sel < 10) begin
         raw = {16'h0000, 16'($urandom_range(0, 65535))};
      end else if (sel < 12) begin
         raw = $urandom_range(0, 1) ? 32'h0000_0080 : 32'h0000_0000;
      end else begin
         pick = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         raw  = {16'h0000, ($urandom_range(0, 9) < 6) ? pick : pick + RELEASE_OFS};
      end
      return raw;
   endfunction

   // -------------------------------------------------------------------------
   // Request and configuration drivers.
   // -------------------------------------------------------------------------

   // Sends one key beat. The sender runs in bursts with random gaps between
   // them; the expectation is queued at the edge that accepts the beat.
   task automatic send_key(input logic [hkt_pkg::KEY_W-1:0] raw, input logic typed,
                           input logic [5:0] flags);
      tracker_view_type predicted;
      tracker_view_type typed_view;
      int               gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_key_code <= raw;
      do @(posedge clock); while (req_stall);
      predicted  = track_key(raw);
      typed_view = '0;
      {typed_view.shift_held, typed_view.ctrl_held, typed_view.alt_held,
       typed_view.caps_lock_on, typed_view.modifier_pressed,
       typed_view.code_ignored} = flags;
      expected_views.push_back(typed ? typed_view : predicted);
      beats_sent++;
   endtask

   // Stops sending and waits until every expected beat has come back, then
   // lets the block settle before anything else happens.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hkt_pkg::CSR_IDX_W-1:0] idx,
                            input hkt_pkg::code_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx < hkt_pkg::NUM_REGS) key_map[idx] = data;
      reg_writes++;
   endtask

   // Writes the whole key map back to back, then pokes the unused index,
   // which the block must ignore.
   task automatic load_key_map(input key_map_type map);
      for (int r = hkt_pkg::REG_LEFT_SHIFT; r <= hkt_pkg::REG_CAPS_LOCK; r++)
         write_reg(hkt_pkg::CSR_IDX_W'(r), map[r]);
      write_reg(REG_UNUSED, hkt_pkg::code_type'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Result side: back-pressure pattern and checker.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_window == 0) begin
            stall_mode   = stall_mode_type'($urandom_range(0, 3));
            stall_window = $urandom_range(20, 80);
         end else begin
            stall_window--;
         end
         case (stall_mode)
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_stall <= (stall_window % 8 < 5);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input hkt_pkg::code_type want,
                              input hkt_pkg::code_type got);
      if (want !== got)
         note_failure($sformatf("beat %0d %s: expected 0x%04h, got 0x%04h",
                                beats_checked, name, want, got));
   endtask

   task automatic check_flag(input string name, input logic want, input logic got);
      if (want !== got)
         note_failure($sformatf("beat %0d %s: expected %0b, got %0b",
                                beats_checked, name, want, got));
   endtask

   always @(posedge clock) begin
      tracker_view_type got;
      tracker_view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_slot_zero, rsp_slot_one, rsp_slot_two, rsp_slot_three,
                rsp_slot_four, rsp_slot_five, rsp_shift_held, rsp_ctrl_held,
                rsp_alt_held, rsp_caps_lock_on, rsp_modifier_pressed,
                rsp_code_ignored};
         if (expected_views.size() == 0) begin
            note_failure($sformatf("result beat with nothing expected: %h", got));
         end else begin
            want = expected_views.pop_front();
            check_field("slot_zero", want.slot_zero, got.slot_zero);
            check_field("slot_one", want.slot_one, got.slot_one);
            check_field("slot_two", want.slot_two, got.slot_two);
            check_field("slot_three", want.slot_three, got.slot_three);
            check_field("slot_four", want.slot_four, got.slot_four);
            check_field("slot_five", want.slot_five, got.slot_five);
            check_flag("shift_held", want.shift_held, got.shift_held);
            check_flag("ctrl_held", want.ctrl_held, got.ctrl_held);
            check_flag("alt_held", want.alt_held, got.alt_held);
            check_flag("caps_lock_on", want.caps_lock_on, got.caps_lock_on);
            check_flag("modifier_pressed", want.modifier_pressed,
                       got.modifier_pressed);
            check_flag("code_ignored", want.code_ignored, got.code_ignored);
         end
         beats_checked++;
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d beats outstanding.",
                  cycle_count, expected_views.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin
      map_kind_type kind;

      // Directed table, taken with the reset key map. The first rows run
      // with an empty list and carry their expected flags; the list rows
      // after them are left to the tracker.
      directed_rows = '{
         // Oversized codes, the smallest and the largest.
         '{32'h0001_0000, 1'b1, 6'b000001},
         '{32'hFFFF_FFFF, 1'b1, 6'b000001},
         // Press of code zero with empty slots is dropped.
         '{32'h0000_0000, 1'b1, 6'b000000},
         // Both shifts, then one release clears the shared flag.
         '{32'h0000_002A, 1'b1, 6'b100010},
         '{32'h0000_0036, 1'b1, 6'b100010},
         '{32'h0000_00AA, 1'b1, 6'b000000},
         '{32'h0000_E01D, 1'b1, 6'b010010},
         '{32'h0000_0038, 1'b1, 6'b011010},
         // Caps lock toggles on press; its release is an ordinary lookup.
         '{32'h0000_003A, 1'b1, 6'b011100},
         '{32'h0000_00BA, 1'b1, 6'b011100},
         '{32'h0000_E09D, 1'b1, 6'b001100},
         '{32'h0000_E0B8, 1'b1, 6'b000100},
         '{32'h0000_003A, 1'b1, 6'b000000},
         // Seven presses overflow the list and push out the oldest.
         '{32'h0000_0010, 1'b0, 6'b000000},
         '{32'h0000_0011, 1'b0, 6'b000000},
         '{32'h0000_0012, 1'b0, 6'b000000},
         '{32'h0000_0013, 1'b0, 6'b000000},
         '{32'h0000_0014, 1'b0, 6'b000000},
         '{32'h0000_0015, 1'b0, 6'b000000},
         '{32'h0000_0016, 1'b0, 6'b000000},
         // A repeated press is dropped; code zero gets in on a full list.
         '{32'h0000_0012, 1'b0, 6'b000000},
         '{32'h0000_0000, 1'b0, 6'b000000},
         // A held release, and a release of a key that is no longer listed.
         '{32'h0000_0093, 1'b0, 6'b000000},
         '{32'h0000_0090, 1'b0, 6'b000000},
         // Highest press code, its release through 0xFFFF, release of zero.
         '{32'h0000_FF7F, 1'b0, 6'b000000},
         '{32'h0000_FFFF, 1'b0, 6'b000000},
         '{32'h0000_0080, 1'b0, 6'b000000}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Each phase runs under its own key map. The block keeps its list and
      // flags across phases, so later maps start from a busy state.
      for (int k = MAP_DEFAULT; k <= MAP_RESTORE; k++) begin
         kind = map_kind_type'(k);
         if (kind == MAP_DEFAULT) begin
            foreach (directed_rows[i])
               send_key(directed_rows[i].key, directed_rows[i].typed,
                        directed_rows[i].flags);
         end else begin
            drain();
            load_key_map(choose_map(kind));
         end
         refill_pool();
         repeat (RANDOM_PER_PHASE) send_key(random_key_code(), 1'b0, 6'b000000);
      end

      drain();
      if (expected_views.size() != 0)
         note_failure($sformatf("%0d expected beats never arrived",
                                expected_views.size()));

      $display("Sent %0d key beats (%0d directed) and checked %0d result beats.",
               beats_sent, DIRECTED_ROWS, beats_checked);
      $display("Stepped through %0d key maps with %0d register writes; %0d mismatches.",
               MAP_RESTORE + 1, reg_writes, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
